[rtl/ltfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltfs_pkg
// Shared widths, constants, cell payload types and arctangent table for the triangle solver.
// ----------------------------------------------------------------------------
package ltfs_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int LENGTH_BITS     = 16;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int ANG_Q           = 30;
    localparam int GUARD           = 12;

    // vector datapath: 16+12 bits magnitude, growth and sign headroom
    localparam int VW = 34;
    // angle accumulator, Q2.30 plus sign and headroom for +-pi offset
    localparam int ZW = 34;

    localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sh0C90FDAA2);
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sh06487ED51);
    localparam logic signed [31:0]   INV_GAIN    = 32'sh26DD3B6A;

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [ZW-1:0] ang_t;

    // one side's state as it travels through the rotation chain
    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
        logic neg;
        vec_t m;
    } rot_t;

    // one side's state in the vectoring chain
    typedef struct packed {
        vec_t b;
        vec_t h;
        ang_t z;
    } vct_t;

    function automatic ang_t atan_entry(input int k);
        logic [31:0] t;
        begin
            case (k)
                0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
                3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
                6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
                9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
                12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
                15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
                18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
                21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
                24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
                27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
                30: t = 32'h00000001;
                default: t = 32'h00000000;
            endcase
            atan_entry = ZW'(t);
        end
    endfunction

endpackage

[rtl/landmark_triangle_feature_solver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landmark_triangle_feature_solver
// Solves two side-angle-side triangles per request and reports both edge
// lengths and the corner angle at the middle landmark.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  in      | in_valid/in_ready | range_left angle_left range_mid range_right angle_right
//  out     | out_valid/out_ready | left_edge_length right_edge_length
//          |                   |   mid_corner_angle length_saturated
//
// One request per cycle while the chain advances. The pipeline is the two
// CORDIC chains, their gain-removal registers and the output register. The
// whole chain advances when the output register is empty or being drained,
// so a stalled output holds every stage. Reset clears the stage valid flags only.
// ----------------------------------------------------------------------------
module landmark_triangle_feature_solver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         range_left,
    input  logic signed [14:0]  angle_left,
    input  logic [15:0]         range_mid,
    input  logic [15:0]         range_right,
    input  logic signed [14:0]  angle_right,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         left_edge_length,
    output logic [15:0]         right_edge_length,
    output logic signed [15:0]  mid_corner_angle,
    output logic                length_saturated
);
    import ltfs_pkg::*;

    logic adv;
    logic vl, vr;
    logic [LENGTH_BITS-1:0] el, er;
    logic sl, sr;
    ang_t tl, tr;

    logic ov_reg;
    logic [15:0] le_reg, re_reg;
    logic signed [15:0] ang_reg;
    logic sat_reg;

    assign adv      = !ov_reg || out_ready;
    assign in_ready = adv;

    ltfs_side u_left (
        .clk(clk), .rst_n(rst_n), .adv(adv), .vin(in_valid),
        .a_in(range_left), .t_in(angle_left), .m_in(range_mid),
        .vout(vl), .edge_len(el), .sat(sl), .theta(tl)
    );

    ltfs_side u_right (
        .clk(clk), .rst_n(rst_n), .adv(adv), .vin(in_valid),
        .a_in(range_right), .t_in(angle_right), .m_in(range_mid),
        .vout(vr), .edge_len(er), .sat(sr), .theta(tr)
    );

    localparam int SH = ANG_Q - ANGLE_FRAC_BITS;

    logic signed [ZW:0] sum_w, sum_s;
    logic signed [15:0] ang_next;

    always_comb
    begin
        sum_w = (ZW+1)'(tl) + (ZW+1)'(tr) + (ZW+1)'(64'sd1 <<< (SH - 1));
        sum_s = sum_w >>> SH;
        if (sum_s > 32767)
            ang_next = 16'sh7FFF;
        else if (sum_s < -32768)
            ang_next = -16'sh8000;
        else
            ang_next = 16'(sum_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= vl & vr;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            le_reg  <= 16'(el);
            re_reg  <= 16'(er);
            ang_reg <= ang_next;
            sat_reg <= sl | sr;
        end
    end

    assign out_valid         = ov_reg;
    assign left_edge_length  = le_reg;
    assign right_edge_length = re_reg;
    assign mid_corner_angle  = ang_reg;
    assign length_saturated  = sat_reg;

endmodule

[rtl/ltfs_rot_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltfs_rot_cell
// One rotation-mode CORDIC step; shift and table entry are tied off per
// position in the chain, registered when the chain advances.
// ----------------------------------------------------------------------------
module ltfs_rot_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [4:0]       shift,
    input  ltfs_pkg::ang_t   at,
    input  logic             vin,
    input  ltfs_pkg::rot_t   din,
    output logic             vout,
    output ltfs_pkg::rot_t   dout
);
    import ltfs_pkg::*;

    rot_t d_next;
    rot_t d_reg;
    logic v_reg;

    always_comb
    begin
        d_next = din;
        if (din.z >= 0)
        begin
            d_next.x = din.x - (din.y >>> shift);
            d_next.y = din.y + (din.x >>> shift);
            d_next.z = din.z - at;
        end
        else
        begin
            d_next.x = din.x + (din.y >>> shift);
            d_next.y = din.y - (din.x >>> shift);
            d_next.z = din.z + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (adv)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

[rtl/ltfs_vec_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltfs_vec_cell
// One vectoring-mode CORDIC step; shift and table entry are tied off per
// position in the chain, registered.
// ----------------------------------------------------------------------------
module ltfs_vec_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [4:0]       shift,
    input  ltfs_pkg::ang_t   at,
    input  logic             vin,
    input  ltfs_pkg::vct_t   din,
    output logic             vout,
    output ltfs_pkg::vct_t   dout
);
    import ltfs_pkg::*;

    vct_t d_next;
    vct_t d_reg;
    logic v_reg;

    always_comb
    begin
        d_next = din;
        if (din.h >= 0)
        begin
            d_next.b = din.b + (din.h >>> shift);
            d_next.h = din.h - (din.b >>> shift);
            d_next.z = din.z + at;
        end
        else
        begin
            d_next.b = din.b - (din.h >>> shift);
            d_next.h = din.h + (din.b >>> shift);
            d_next.z = din.z - at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (adv)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

[rtl/ltfs_side.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltfs_side
// Solves one side-angle-side triangle: rotation chain, gain removal, base
// and height, vectoring chain, gain removal, rounding and clipping.
// ----------------------------------------------------------------------------
module ltfs_side (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 vin,
    input  logic [15:0]          a_in,
    input  logic signed [14:0]   t_in,
    input  logic [15:0]          m_in,
    output logic                 vout,
    output logic [ltfs_pkg::LENGTH_BITS-1:0] edge_len,
    output logic                 sat,
    output ltfs_pkg::ang_t       theta
);
    import ltfs_pkg::*;

    // ---------------- entry: fold wide angles
    rot_t r0;
    ang_t z_in;

    always_comb
    begin
        z_in    = ZW'(t_in) <<< (ANG_Q - ANGLE_FRAC_BITS);
        r0.x    = vec_t'({a_in, GUARD'(0)});
        r0.y    = '0;
        r0.m    = vec_t'({m_in, GUARD'(0)});
        r0.neg  = 1'b0;
        r0.z    = z_in;
        if (z_in > HALF_PI_Q30)
        begin
            r0.z   = z_in - PI_Q30;
            r0.neg = 1'b1;
        end
        else if (z_in < -HALF_PI_Q30)
        begin
            r0.z   = z_in + PI_Q30;
            r0.neg = 1'b1;
        end
    end

    rot_t rd [CORDIC_STEPS+1];
    logic rv [CORDIC_STEPS+1];
    assign rd[0] = r0;
    assign rv[0] = vin;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        ltfs_rot_cell u_cell (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .shift(5'(i)), .at(atan_entry(i)),
            .vin(rv[i]), .din(rd[i]), .vout(rv[i+1]), .dout(rd[i+1])
        );
    end

    // ---------------- gain removal, two multiplies in one stage
    // rotated vector stays below 2^29, so 32 bits carry it
    rot_t rf;
    assign rf = rd[CORDIC_STEPS];

    logic signed [31:0]      xs, ys;
    logic signed [63:0]      px_next, py_next;
    logic signed [VW-1:0]    gx, gy;
    vec_t m1_reg;
    logic neg1_reg, v1_reg;
    logic signed [63:0]      px_reg, py_reg;

    assign xs      = rf.x[31:0];
    assign ys      = rf.y[31:0];
    assign px_next = xs * INV_GAIN;
    assign py_next = ys * INV_GAIN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= rv[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            m1_reg   <= rf.m;
            neg1_reg <= rf.neg;
        end
    end

    // ---------------- base and height, fold negative base
    vct_t v0;
    vec_t bb, hh;

    always_comb
    begin
        gx = VW'(px_reg >>> ANG_Q);
        gy = VW'(py_reg >>> ANG_Q);
        if (neg1_reg)
        begin
            gx = -gx;
            gy = -gy;
        end
        hh   = gy;
        bb   = m1_reg - gx;
        v0.z = '0;
        v0.b = bb;
        v0.h = hh;
        if (bb < 0)
        begin
            v0.z = (hh >= 0) ? PI_Q30 : -PI_Q30;
            v0.b = -bb;
            v0.h = -hh;
        end
    end

    vct_t vd [CORDIC_STEPS+1];
    logic vv [CORDIC_STEPS+1];
    assign vd[0] = v0;
    assign vv[0] = v1_reg;

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_vec
        ltfs_vec_cell u_cell (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .shift(5'(j)), .at(atan_entry(j)),
            .vin(vv[j]), .din(vd[j]), .vout(vv[j+1]), .dout(vd[j+1])
        );
    end

    // ---------------- magnitude gain removal
    // magnitude before gain removal stays below 2^31
    vct_t vf;
    assign vf = vd[CORDIC_STEPS];

    logic signed [31:0] bs;
    logic signed [63:0] pm_reg;
    ang_t z2_reg;
    logic v2_reg;

    assign bs = vf.b[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= vv[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pm_reg <= bs * INV_GAIN;
            z2_reg <= (vf.b == 0 && vf.h == 0) ? '0 : vf.z;
        end
    end

    // ---------------- round, clip
    localparam logic [VW-1:0] LIM = VW'((64'd1 << LENGTH_BITS) - 64'd1);
    vec_t mg, mr;

    always_comb
    begin
        mg = VW'(pm_reg >>> ANG_Q);
        mr = (mg + vec_t'(1 <<< (GUARD - 1))) >>> GUARD;
        sat = 1'b0;
        if (mr < 0)
            edge_len = '0;
        else if (mr > $signed(LIM))
        begin
            edge_len = '1;
            sat      = 1'b1;
        end
        else
            edge_len = LENGTH_BITS'(mr);
    end

    assign theta = z2_reg;
    assign vout  = v2_reg;

endmodule
